@@ src/csvt_pkg.sv @@
`timescale 1ns / 1ps
// Package for the CSV field tokenizer: character constants, register indexes,
// the result record type and the newline folding helper. No dependencies.
package csvt_pkg;

  // Character codes with a fixed meaning.
  localparam logic [7:0] ChLf    = 8'd10;
  localparam logic [7:0] ChCr    = 8'd13;
  localparam logic [7:0] ChSpace = 8'd32;

  // Reset values of the configuration registers.
  localparam logic [7:0] DelimReset = 8'd44;
  localparam logic [7:0] QuoteReset = 8'd34;

  // Configuration port layout.
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;
  localparam logic [CfgIdxW-1:0] CfgDelim = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgQuote = 2'd1;

  // Result queue depth; one byte produces at most two results.
  localparam int unsigned QDepth  = 4;
  localparam int unsigned QCountW = $clog2(QDepth + 1);

  typedef struct packed {
    logic       has_char;
    logic [7:0] out_char;
    logic       field_end;
    logic       record_end;
    logic       last_result;
  } result_t;

  typedef struct packed {
    logic       emit;
    logic [7:0] ch;
    logic       after_space;
  } fold_t;

  // Adds one byte to the field: LF and CR become one space unless the
  // previous field byte already was a space.
  function automatic fold_t fold_char(input logic [7:0] c, input logic after_space);
    fold_t f;
    if (c == ChLf || c == ChCr) begin
      f.emit        = !after_space;
      f.ch          = ChSpace;
      f.after_space = 1'b1;
    end else begin
      f.emit        = 1'b1;
      f.ch          = c;
      f.after_space = (c == ChSpace);
    end
    return f;
  endfunction

endpackage

@@ src/csvt_if.sv @@
`timescale 1ns / 1ps
// Channel interfaces for the CSV field tokenizer: the byte input channel and
// the result output channel. No dependencies.
interface csvt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_input;

  modport source (output valid, output data_byte, output end_of_input, input ready);
  modport sink   (input valid, input data_byte, input end_of_input, output ready);
endinterface

interface csvt_out_if;
  logic       valid;
  logic       ready;
  logic       has_char;
  logic [7:0] out_char;
  logic       field_end;
  logic       record_end;
  logic       last_result;

  modport source (output valid, output has_char, output out_char, output field_end,
                  output record_end, output last_result, input ready);
  modport sink   (input valid, input has_char, input out_char, input field_end,
                  input record_end, input last_result, output ready);
endinterface

@@ src/csvt_core.sv @@
`timescale 1ns / 1ps
// Tokenizer decode: quote, delimiter and newline handling for one byte, the
// parser state and the configuration registers. Depends on csvt_pkg.
module csvt_core
  import csvt_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          data_byte_i,
  input  logic                end_of_input_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output result_t             res0_o,
  output result_t             res1_o,
  output logic [1:0]          res_cnt_o
);

  logic [7:0] delim_q, quote_q;
  logic       in_quotes_q, in_quotes_d;
  logic       pending_q, pending_d;
  logic       after_space_q, after_space_d;

  // Next state and up to two results for the byte on the input channel.
  always_comb begin
    logic    is_quote, done, rec, sp, iq, qp, asp;
    logic    byte_res;
    result_t br, fr;
    fold_t   f;

    is_quote = (data_byte_i == quote_q) && (data_byte_i != ChLf);
    done     = 1'b0;
    rec      = 1'b0;
    sp       = 1'b0;
    iq       = in_quotes_q;
    qp       = pending_q;
    asp      = after_space_q;
    byte_res = 1'b0;
    br       = '0;
    fr       = '0;
    f        = '0;

    // Resolve a quote held from the previous byte.
    if (qp) begin
      qp = 1'b0;
      if (is_quote) begin
        f        = fold_char(quote_q, asp);
        asp      = f.after_space;
        byte_res = f.emit;
        br.has_char = 1'b1;
        br.out_char = f.ch;
        done     = 1'b1;
      end else begin
        iq = 1'b0;
      end
    end

    // Classify the byte itself.
    if (!done) begin
      if (data_byte_i == ChLf) begin
        if (iq) begin
          f        = fold_char(ChLf, asp);
          asp      = f.after_space;
          byte_res = f.emit;
          br.has_char = 1'b1;
          br.out_char = f.ch;
        end else begin
          byte_res      = 1'b1;
          br.field_end  = 1'b1;
          br.record_end = 1'b1;
          asp           = 1'b0;
          rec           = 1'b1;
        end
      end else if (is_quote) begin
        if (iq) begin
          qp = 1'b1;
        end else begin
          iq = 1'b1;
        end
      end else if (data_byte_i == delim_q && !iq) begin
        byte_res     = 1'b1;
        br.field_end = 1'b1;
        asp          = 1'b0;
      end else begin
        f        = fold_char(data_byte_i, asp);
        asp      = f.after_space;
        byte_res = f.emit;
        br.has_char = 1'b1;
        br.out_char = f.ch;
      end
    end

    // Flush an open field at end of input.
    fr.field_end  = 1'b1;
    fr.record_end = 1'b1;
    if (end_of_input_i) begin
      if (qp) begin
        qp = 1'b0;
        iq = 1'b0;
      end
      sp          = iq && !asp;
      fr.has_char = sp;
      fr.out_char = sp ? ChSpace : 8'd0;
      iq          = 1'b0;
      asp         = 1'b0;
    end

    // Pack the results in order and mark the final one.
    res0_o    = '0;
    res1_o    = '0;
    res_cnt_o = 2'd0;
    if (byte_res) begin
      res0_o    = br;
      res_cnt_o = 2'd1;
      if (end_of_input_i && !rec) begin
        res1_o             = fr;
        res1_o.last_result = 1'b1;
        res_cnt_o          = 2'd2;
      end else begin
        res0_o.last_result = 1'b1;
      end
    end else if (end_of_input_i && !rec) begin
      res0_o             = fr;
      res0_o.last_result = 1'b1;
      res_cnt_o          = 2'd1;
    end

    in_quotes_d   = iq;
    pending_d     = qp;
    after_space_d = asp;
  end

  // Parser state advances once per accepted transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_quotes_q   <= 1'b0;
      pending_q     <= 1'b0;
      after_space_q <= 1'b0;
    end else if (accept_i) begin
      in_quotes_q   <= in_quotes_d;
      pending_q     <= pending_d;
      after_space_q <= after_space_d;
    end
  end

  // Configuration registers; indexes beyond the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q <= DelimReset;
      quote_q <= QuoteReset;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgDelim) begin
        delim_q <= cfg_wdata_i;
      end else if (cfg_idx_i == CfgQuote) begin
        quote_q <= cfg_wdata_i;
      end
    end
  end

endmodule

@@ src/csvt_queue.sv @@
`timescale 1ns / 1ps
// Result queue: a short shifting register queue that takes up to two results
// per cycle and hands out one. Depends on csvt_pkg.
module csvt_queue
  import csvt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  logic [1:0] push_cnt_i,
  input  result_t    res0_i,
  input  result_t    res1_i,
  output logic       space_o,
  output logic       valid_o,
  input  logic       pop_i,
  output result_t    head_o
);

  result_t              entry_q [QDepth];
  result_t              entry_d [QDepth];
  logic [QCountW-1:0]   count_q, count_d;

  // Shift on pop, then write new results behind the remaining ones.
  always_comb begin
    logic [QCountW-1:0] base;
    logic [QCountW-1:0] n;

    base = count_q - QCountW'(pop_i);
    n    = push_i ? QCountW'(push_cnt_i) : '0;
    for (int i = 0; i < QDepth; i++) begin
      if (pop_i && i < QDepth - 1) begin
        entry_d[i] = entry_q[i+1];
      end else begin
        entry_d[i] = entry_q[i];
      end
      if (n != '0 && QCountW'(i) == base) begin
        entry_d[i] = res0_i;
      end
      if (n == QCountW'(2) && QCountW'(i) == base + QCountW'(1)) begin
        entry_d[i] = res1_i;
      end
    end
    count_d = base + n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QDepth; i++) begin
      entry_q[i] <= entry_d[i];
    end
  end

  // Room for two more results is always kept before a byte is taken.
  assign space_o = count_q < QCountW'(QDepth - 1);
  assign valid_o = count_q != '0;
  assign head_o  = entry_q[0];

endmodule

@@ src/csv_field_tokenizer.sv @@
`timescale 1ns / 1ps
// Top level of the CSV field tokenizer: byte decode plus result queue.
// Depends on csvt_pkg, csvt_if, csvt_core and csvt_queue.
//
//   Channel | Direction | Handshake    | Payload
//   in_i    | input     | valid/ready  | data_byte, end_of_input
//   out_o   | output    | valid/ready  | has_char, out_char, field_end, record_end,
//           |           |              | last_result
//   cfg     | input     | cfg_we_i     | cfg_idx_i, cfg_wdata_i
//
// One byte is taken per cycle while the queue has room; each byte gives zero,
// one or, on the last byte of a file, two results, which leave one per cycle
// while the receiver is ready from a four-entry result queue. Ready is high
// whenever the queue holds two results or fewer, so it depends only on the queue
// count register. Results enter the queue when their byte is taken. Reset restores
// the parser state and the default delimiter and quote; there is no clearing pass.
module csv_field_tokenizer
  import csvt_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  csvt_in_if.sink             in_i,
  csvt_out_if.source          out_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  result_t    res0, res1, head;
  logic [1:0] res_cnt;
  logic       space, accept, pop, q_valid;

  assign in_i.ready = space;
  assign accept     = in_i.valid && space;
  assign pop        = q_valid && out_o.ready;

  csvt_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .data_byte_i   (in_i.data_byte),
    .end_of_input_i(in_i.end_of_input),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .res0_o        (res0),
    .res1_o        (res1),
    .res_cnt_o     (res_cnt)
  );

  csvt_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (accept),
    .push_cnt_i(res_cnt),
    .res0_i    (res0),
    .res1_i    (res1),
    .space_o   (space),
    .valid_o   (q_valid),
    .pop_i     (pop),
    .head_o    (head)
  );

  // Drive the result channel from the head of the queue.
  assign out_o.valid       = q_valid;
  assign out_o.has_char    = head.has_char;
  assign out_o.out_char    = head.out_char;
  assign out_o.field_end   = head.field_end;
  assign out_o.record_end  = head.record_end;
  assign out_o.last_result = head.last_result;

endmodule

@@ tb/tb_csv_field_tokenizer.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for csv_field_tokenizer: drives file bytes, predicts
// field characters and end marks, and compares every result transaction.
// Depends on csvt_pkg, csvt_if and the csv_field_tokenizer RTL.
module tb_csv_field_tokenizer;
  import csvt_pkg::*;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned IdlePct    = 23;
  localparam int unsigned MaxPrinted = 40;

  // Indexes past the last register; writes to them must change nothing.
  localparam logic [CfgIdxW-1:0] CfgSpareA = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpareB = 2'd3;

  localparam logic [7:0] ChLowA  = "a";
  localparam logic [7:0] ChComma = ",";
  localparam logic [7:0] ChQuote = QuoteReset;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;

  csvt_in_if  byte_ch ();
  csvt_out_if tok_ch ();

  csv_field_tokenizer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (byte_ch),
    .out_o       (tok_ch),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // Tokenizer state as predicted by the testbench.
  logic [7:0] delim_m;
  logic [7:0] quote_m;
  logic       in_quotes_m;
  logic       quote_held_m;
  logic       after_space_m;

  result_t step_tokens[$];
  result_t expected_tokens[$];
  result_t seen_tok;
  result_t want_tok;

  int errors    = 0;
  int n_sent    = 0;
  int n_checked = 0;
  int stall_cnt = 0;
  int hold_left = 0;
  bit idle_on   = 1'b1;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    if (errors <= MaxPrinted) begin
      $display("mismatch at result %0d: %s got 0x%0h expected 0x%0h",
               n_checked, what, got, want);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  task automatic reset_tokenizer_model();
    delim_m       = DelimReset;
    quote_m       = QuoteReset;
    in_quotes_m   = 1'b0;
    quote_held_m  = 1'b0;
    after_space_m = 1'b0;
  endtask

  task automatic emit_token(input logic has, input logic [7:0] ch, input logic fe,
                            input logic re);
    result_t r;
    r.has_char    = has;
    r.out_char    = ch;
    r.field_end   = fe;
    r.record_end  = re;
    r.last_result = 1'b0;
    step_tokens = {step_tokens, r};
  endtask

  // Adds one byte to the current field; LF and CR fold into a single space.
  task automatic fold_into_field(input logic [7:0] c);
    if (c == ChLf || c == ChCr) begin
      if (!after_space_m) begin
        after_space_m = 1'b1;
        emit_token(1'b1, ChSpace, 1'b0, 1'b0);
      end
    end else begin
      after_space_m = (c == ChSpace);
      emit_token(1'b1, c, 1'b0, 1'b0);
    end
  endtask

  task automatic tokenize_byte(input logic [7:0] c, input logic eoi);
    logic    is_quote;
    logic    taken;
    logic    rec_end;
    logic    pad;
    result_t r;
    is_quote = (c == quote_m) && (c != ChLf);
    taken    = 1'b0;
    rec_end  = 1'b0;
    step_tokens.delete();

    // A quote held from the last byte is either doubled or closes the quotes.
    if (quote_held_m) begin
      quote_held_m = 1'b0;
      if (is_quote) begin
        fold_into_field(quote_m);
        taken = 1'b1;
      end else begin
        in_quotes_m = 1'b0;
      end
    end

    if (!taken) begin
      if (c == ChLf) begin
        if (in_quotes_m) begin
          fold_into_field(ChLf);
        end else begin
          emit_token(1'b0, 8'd0, 1'b1, 1'b1);
          after_space_m = 1'b0;
          rec_end       = 1'b1;
        end
      end else if (is_quote) begin
        if (in_quotes_m) quote_held_m = 1'b1;
        else in_quotes_m = 1'b1;
      end else if (c == delim_m && !in_quotes_m) begin
        emit_token(1'b0, 8'd0, 1'b1, 1'b0);
        after_space_m = 1'b0;
      end else begin
        fold_into_field(c);
      end
    end

    // End of input flushes the open field unless the byte closed a record.
    if (eoi) begin
      if (quote_held_m) begin
        quote_held_m = 1'b0;
        in_quotes_m  = 1'b0;
      end
      if (!rec_end) begin
        pad = in_quotes_m && !after_space_m;
        emit_token(pad, pad ? ChSpace : 8'd0, 1'b1, 1'b1);
      end
      in_quotes_m   = 1'b0;
      after_space_m = 1'b0;
    end

    if (step_tokens.size() > 0) begin
      r = step_tokens.pop_back();
      r.last_result = 1'b1;
      step_tokens = {step_tokens, r};
    end
    expected_tokens = {expected_tokens, step_tokens};
  endtask

  task automatic apply_reg(input logic [CfgIdxW-1:0] idx, input logic [7:0] val);
    case (idx)
      CfgDelim: delim_m = val;
      CfgQuote: quote_m = val;
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_byte(input logic [7:0] c, input logic eoi);
    while (idle_on && ($urandom_range(99) < IdlePct)) begin
      byte_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    byte_ch.valid        <= 1'b1;
    byte_ch.data_byte    <= c;
    byte_ch.end_of_input <= eoi;
    do @(posedge clk_i); while (!byte_ch.ready);
    tokenize_byte(c, eoi);
    n_sent++;
    @(negedge clk_i);
  endtask

  // Stops offering bytes and waits until every predicted result has arrived.
  task automatic wait_drained();
    byte_ch.valid <= 1'b0;
    while (expected_tokens.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_regs(input logic [CfgIdxW-1:0] idx_a, input logic [7:0] val_a,
                            input logic [CfgIdxW-1:0] idx_b, input logic [7:0] val_b);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx_a;
    cfg_wdata <= val_a;
    apply_reg(idx_a, val_a);
    @(negedge clk_i);
    cfg_idx   <= idx_b;
    cfg_wdata <= val_b;
    apply_reg(idx_b, val_b);
    @(negedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic [7:0] rand_letter();
    return ChLowA + 8'($urandom_range(25));
  endfunction

  // One record of random fields, quoted or not, that may hold arbitrary bytes.
  task automatic send_record();
    int         n_fields;
    int         len;
    int         pick;
    logic       quoted;
    logic [7:0] c;
    n_fields = $urandom_range(5, 1);
    for (int f = 0; f < n_fields; f++) begin
      quoted = ($urandom_range(2) == 0);
      if (quoted) send_byte(quote_m, 1'b0);
      len = $urandom_range(8);
      for (int i = 0; i < len; i++) begin
        pick = $urandom_range(99);
        if (pick < 55) c = rand_letter();
        else if (pick < 65) c = ChSpace;
        else if (pick < 72) c = ChCr;
        else if (pick < 80) c = quoted ? ChLf : rand_letter();
        else if (pick < 88) c = 8'($urandom_range(255));
        else if (pick < 94) c = quoted ? delim_m : rand_letter();
        else begin
          // A doubled quote inside quotes stands for one literal quote.
          if (quoted) send_byte(quote_m, 1'b0);
          c = quoted ? quote_m : rand_letter();
        end
        send_byte(c, 1'b0);
      end
      if (quoted) send_byte(quote_m, 1'b0);
      if (f < n_fields - 1) send_byte(delim_m, 1'b0);
    end
    pick = $urandom_range(99);
    if (pick < 8) send_byte(ChLf, 1'b1);
    else if (pick < 14) send_byte(rand_letter(), 1'b1);
    else send_byte(ChLf, 1'b0);
  endtask

  // Arbitrary bytes, now and then marked as the end of the file.
  task automatic send_noise();
    int n;
    n = $urandom_range(6, 1);
    repeat (n) send_byte(8'($urandom_range(255)), $urandom_range(15) == 0);
  endtask

  task automatic run_phase(input logic [7:0] delim, input logic [7:0] quote, input int count);
    int target;
    wait_drained();
    write_regs(CfgDelim, delim, CfgQuote, quote);
    target = n_sent + count;
    while (n_sent < target) begin
      if ($urandom_range(99) < 85) send_record();
      else send_noise();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: ready generation and checking
  // ---------------------------------------------------------------------------

  // The receiver stalls at random, or for a whole stretch when one is requested.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      tok_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else begin
      tok_ch.ready <= !idle_on || ($urandom_range(99) >= IdlePct);
    end
  end

  // Each result transaction is compared with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && tok_ch.valid && tok_ch.ready) begin
      seen_tok.has_char    = tok_ch.has_char;
      seen_tok.out_char    = tok_ch.out_char;
      seen_tok.field_end   = tok_ch.field_end;
      seen_tok.record_end  = tok_ch.record_end;
      seen_tok.last_result = tok_ch.last_result;
      if (expected_tokens.size() == 0) begin
        report_mismatch("result with nothing expected", int'(seen_tok), 0);
      end else begin
        want_tok = expected_tokens.pop_front();
        if (seen_tok.has_char != want_tok.has_char)
          report_mismatch("has_char", int'(seen_tok.has_char), int'(want_tok.has_char));
        if (seen_tok.out_char != want_tok.out_char)
          report_mismatch("out_char", int'(seen_tok.out_char), int'(want_tok.out_char));
        if (seen_tok.field_end != want_tok.field_end)
          report_mismatch("field_end", int'(seen_tok.field_end), int'(want_tok.field_end));
        if (seen_tok.record_end != want_tok.record_end)
          report_mismatch("record_end", int'(seen_tok.record_end),
                          int'(want_tok.record_end));
        if (seen_tok.last_result != want_tok.last_result)
          report_mismatch("last_result", int'(seen_tok.last_result),
                          int'(want_tok.last_result));
      end
      n_checked++;
    end
  end

  // Watchdog: too many cycles without any transaction ends the run.
  always @(posedge clk_i) begin
    if (!rst_ni || (byte_ch.valid && byte_ch.ready) || (tok_ch.valid && tok_ch.ready)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= StallLimit) begin
      $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
               stall_cnt, expected_tokens.size());
      $display("csv_field_tokenizer verification failed");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Default delimiter and quote: byte extremes, delimiters, doubled quotes,
  // newline folding inside and outside quotes, and a record end.
  task automatic test_default_quoting();
    send_byte(ChLowA, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(ChComma, 1'b0);
    send_byte(ChQuote, 1'b0);
    send_byte(ChComma, 1'b0);
    send_byte(ChQuote, 1'b0);
    send_byte(ChQuote, 1'b0);
    send_byte(ChCr, 1'b0);
    send_byte(ChLf, 1'b0);
    send_byte(ChQuote, 1'b0);
    send_byte(ChComma, 1'b0);
    send_byte(ChSpace, 1'b0);
    send_byte(ChCr, 1'b0);
    send_byte(ChLf, 1'b0);
  endtask

  // End of input: open quotes, a quote pending on the last byte, a last byte
  // that ends a record, and a last byte that gives two results.
  task automatic test_end_of_input();
    send_byte(ChQuote, 1'b1);
    send_byte("q", 1'b0);
    send_byte(ChQuote, 1'b0);
    send_byte(ChQuote, 1'b1);
    send_byte("k", 1'b0);
    send_byte(ChLf, 1'b1);
    send_byte("z", 1'b1);
  endtask

  // Register corners: newline as quote and delimiter, quote equal to the
  // delimiter, CR as quote, extreme codes and writes to unused indexes.
  task automatic test_register_corners();
    wait_drained();
    write_regs(CfgDelim, ChLf, CfgQuote, ChLf);
    send_byte(ChLowA, 1'b0);
    send_byte(ChLf, 1'b0);
    send_byte(ChLf, 1'b1);

    wait_drained();
    write_regs(CfgDelim, ";", CfgQuote, ";");
    send_byte(";", 1'b0);
    send_byte("b", 1'b0);
    send_byte(";", 1'b0);
    send_byte(";", 1'b0);
    send_byte(";", 1'b1);

    wait_drained();
    write_regs(CfgDelim, ChComma, CfgQuote, ChCr);
    send_byte(ChCr, 1'b0);
    send_byte(ChLowA, 1'b0);
    send_byte(ChCr, 1'b0);
    send_byte(ChCr, 1'b0);
    send_byte(ChSpace, 1'b1);

    wait_drained();
    write_regs(CfgDelim, 8'h00, CfgQuote, 8'hFF);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);

    wait_drained();
    write_regs(CfgSpareA, 8'($urandom_range(255)), CfgSpareB, 8'($urandom_range(255)));
    send_byte(8'h00, 1'b1);
  endtask

  // The receiver holds off while bytes keep coming, then the sender waits
  // for every result before going on.
  task automatic test_back_pressure();
    wait_drained();
    write_regs(CfgDelim, DelimReset, CfgQuote, QuoteReset);
    @(posedge clk_i);
    hold_left = HoldCycles;
    @(negedge clk_i);
    repeat (40) send_byte(rand_letter(), 1'b0);
    wait_drained();
  endtask

  // Random files under a range of delimiter and quote settings; the first
  // phase runs with no idling on either side.
  task automatic test_random_files();
    logic [7:0] shared;
    wait_drained();
    @(posedge clk_i);
    idle_on = 1'b0;
    @(negedge clk_i);
    run_phase(DelimReset, QuoteReset, 250);
    wait_drained();
    @(posedge clk_i);
    idle_on = 1'b1;
    @(negedge clk_i);
    run_phase(";", "'", 200);
    run_phase("\t", QuoteReset, 200);
    run_phase(8'h00, 8'hFF, 200);
    run_phase(8'hFF, 8'h00, 200);
    shared = 8'($urandom_range(255));
    run_phase(shared, shared, 200);
    run_phase(ChComma, ChCr, 200);
    run_phase("|", ChSpace, 200);
    run_phase(8'($urandom_range(255)), 8'($urandom_range(255)), 200);
  endtask

  initial begin
    rst_ni               = 1'b0;
    cfg_we               = 1'b0;
    cfg_idx              = CfgDelim;
    cfg_wdata            = '0;
    byte_ch.valid        = 1'b0;
    byte_ch.data_byte    = '0;
    byte_ch.end_of_input = 1'b0;
    tok_ch.ready         = 1'b0;
    reset_tokenizer_model();
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_default_quoting();
    test_end_of_input();
    test_register_corners();
    test_back_pressure();
    test_random_files();

    wait_drained();
    repeat (8) @(negedge clk_i);
    if (errors == 0) begin
      $display("csv_field_tokenizer verification clean");
    end else begin
      $display("csv_field_tokenizer verification failed");
    end
    $finish;
  end

endmodule
